// File: rtl/core/sta_pkg.sv
package sta_pkg;

    localparam int unsigned LIGHT_W = 10;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Register reset values.
    localparam logic [LIGHT_W-1:0] DEADBAND_RST  = 10'd5;
    localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 16'd5000;
    localparam logic [DUTY_W-1:0]  FWD_OFF_RST   = 8'd120;
    localparam logic [DUTY_W-1:0]  REV_OFF_RST   = 8'd130;
    localparam logic [DUTY_W-1:0]  LIMIT_RST     = 8'd150;
    localparam logic [PCT_W-1:0]   TRAVEL_MIN_RST = 7'd0;
    localparam logic [PCT_W-1:0]   TRAVEL_MAX_RST = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND   = 3'd0,
        CFG_HOLDOFF    = 3'd1,
        CFG_FWD_OFFSET = 3'd2,
        CFG_REV_OFFSET = 3'd3,
        CFG_DRV_LIMIT  = 3'd4,
        CFG_TRAVEL_MIN = 3'd5,
        CFG_TRAVEL_MAX = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_motor_dir;

    typedef struct packed {
        logic [LIGHT_W-1:0] deadband;
        logic [HOLD_W-1:0]  holdoff_ms;
        logic [DUTY_W-1:0]  forward_offset;
        logic [DUTY_W-1:0]  reverse_offset;
        logic [DUTY_W-1:0]  drive_limit;
        logic [PCT_W-1:0]   travel_min_pct;
        logic [PCT_W-1:0]   travel_max_pct;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] last_stop_time;
        t_motor_dir        direction;
        logic [DUTY_W-1:0] duty;
    } t_drive_state;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [LIGHT_W-1:0] light_east;
        logic [LIGHT_W-1:0] light_west;
        logic               limit_east;
        logic               limit_west;
        logic [PCT_W-1:0]   position_pct;
    } t_step_in;

endpackage

// File: rtl/core/sta_cfg.sv
module sta_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sta_pkg::t_cfg                      o_cfg
);
    import sta_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEADBAND:   n_cfg.deadband       = i_cfg_data[LIGHT_W-1:0];
                CFG_HOLDOFF:    n_cfg.holdoff_ms     = i_cfg_data[HOLD_W-1:0];
                CFG_FWD_OFFSET: n_cfg.forward_offset = i_cfg_data[DUTY_W-1:0];
                CFG_REV_OFFSET: n_cfg.reverse_offset = i_cfg_data[DUTY_W-1:0];
                CFG_DRV_LIMIT:  n_cfg.drive_limit    = i_cfg_data[DUTY_W-1:0];
                CFG_TRAVEL_MIN: n_cfg.travel_min_pct = i_cfg_data[PCT_W-1:0];
                CFG_TRAVEL_MAX: n_cfg.travel_max_pct = i_cfg_data[PCT_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband       <= DEADBAND_RST;
            r_cfg.holdoff_ms     <= HOLDOFF_RST;
            r_cfg.forward_offset <= FWD_OFF_RST;
            r_cfg.reverse_offset <= REV_OFF_RST;
            r_cfg.drive_limit    <= LIMIT_RST;
            r_cfg.travel_min_pct <= TRAVEL_MIN_RST;
            r_cfg.travel_max_pct <= TRAVEL_MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/sta_step.sv
module sta_step (
    input  sta_pkg::t_cfg         i_cfg,
    input  sta_pkg::t_step_in     i_step,
    input  sta_pkg::t_drive_state i_state,
    output sta_pkg::t_drive_state o_state,
    output logic                  o_held
);
    import sta_pkg::*;

    logic signed [LIGHT_W:0] diff;
    logic [LIGHT_W-1:0]      mag;
    logic [TIME_W-1:0]       elapsed;
    logic                    in_deadband;
    logic                    in_holdoff;
    logic [LIGHT_W:0]        offset_sum;
    logic [DUTY_W-1:0]       clamped;
    logic                    fwd_block;
    logic                    rev_block;

    always_comb begin
        diff = $signed({1'b0, i_step.light_west}) - $signed({1'b0, i_step.light_east});
        // Magnitude of an 11-bit difference of two 10-bit levels fits in 10 bits.
        mag  = diff[LIGHT_W] ? LIGHT_W'(-diff) : diff[LIGHT_W-1:0];
        in_deadband = mag < i_cfg.deadband;
        elapsed     = i_step.now_ms - i_state.last_stop_time;
        in_holdoff  = elapsed < {{(TIME_W-HOLD_W){1'b0}}, i_cfg.holdoff_ms};

        offset_sum = {1'b0, mag}
                   + {3'b000, diff[LIGHT_W] ? i_cfg.reverse_offset : i_cfg.forward_offset};
        clamped    = (offset_sum > {3'b000, i_cfg.drive_limit}) ?
                     i_cfg.drive_limit : offset_sum[DUTY_W-1:0];

        fwd_block = i_step.limit_west || (i_step.position_pct > i_cfg.travel_max_pct)
                 || (i_step.position_pct > PCT_FULL);
        rev_block = i_step.limit_east || (i_step.position_pct < i_cfg.travel_min_pct);

        o_state = i_state;
        o_held  = 1'b0;
        if (in_deadband) begin
            o_state.direction      = DIR_STOP;
            o_state.duty           = '0;
            o_state.last_stop_time = i_step.now_ms;
        end else if (in_holdoff) begin
            o_held = 1'b1;
        end else if (diff != '0) begin
            if (diff[LIGHT_W] ? rev_block : fwd_block) begin
                o_state.direction = DIR_STOP;
                o_state.duty      = '0;
            end else begin
                o_state.direction = diff[LIGHT_W] ? DIR_REV : DIR_FWD;
                o_state.duty      = clamped;
            end
        end
    end

endmodule

// File: rtl/core/solar_tracker_axis_drive.sv
// Single-axis tracker drive: one result beat for every input beat.
// A beat accepted into the input register moves through the step logic into the
// output register when that register is free or being emptied.
// Throughput: one beat per cycle while the output is not stalled; the step logic
// between the registers reads and updates the drive state in that same cycle.
// Reset (synchronous, active low): pipeline empty, drive stopped, stop time 0,
// configuration registers back to their default values.
module solar_tracker_axis_drive (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [sta_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [sta_pkg::LIGHT_W-1:0]        i_light_east,
    input  logic [sta_pkg::LIGHT_W-1:0]        i_light_west,
    input  logic                               i_limit_east,
    input  logic                               i_limit_west,
    input  logic [sta_pkg::PCT_W-1:0]          i_position_pct,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_motor_dir,
    output logic [sta_pkg::DUTY_W-1:0]         o_duty,
    output logic                               o_held
);
    import sta_pkg::*;

    t_cfg         cfg;
    t_step_in     r_in;
    logic         r_in_valid;
    t_drive_state r_state;
    t_drive_state n_state;
    logic         n_held;
    logic         r_out_valid;
    t_motor_dir   r_out_dir;
    logic [DUTY_W-1:0] r_out_duty;
    logic         r_out_held;
    logic         step_fire;
    logic         in_accept;

    sta_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The step logic runs on the held input beat whenever the output register
    // is free or is being emptied in this cycle. The drive state only moves
    // when a step actually fires, so stalls never change its history.
    sta_step u_step (
        .i_cfg   (cfg),
        .i_step  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_held  (n_held)
    );

    assign step_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    // The input register refills in the same cycle that its beat moves on, so
    // a stall upstream is only raised when a full result is blocked downstream.
    assign o_in_stall = r_in_valid && !step_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.now_ms       <= i_now_ms;
            r_in.light_east   <= i_light_east;
            r_in.light_west   <= i_light_west;
            r_in.limit_east   <= i_limit_east;
            r_in.limit_west   <= i_limit_west;
            r_in.position_pct <= i_position_pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_stop_time <= '0;
            r_state.direction      <= DIR_STOP;
            r_state.duty           <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_dir  <= n_state.direction;
            r_out_duty <= n_state.duty;
            r_out_held <= n_held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_motor_dir = r_out_dir;
    assign o_duty      = r_out_duty;
    assign o_held      = r_out_held;

endmodule
